// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk with rst_n low disabling.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define STI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An antecedent that implies a consequent in the next cycle.
`define STI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sti_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted table package
// Shared constants, status codes and cell control types of the sorted table.
// ----------------------------------------------------------------------------
package sti_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int GROUP_SIZE     = 8;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } sti_status_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic op_del;
    logic cmp_en;
    logic ins_en;
    logic del_en;
  } sti_ctrl_t;

  // Compare flags a cell keeps and hands to its right neighbor.
  typedef struct packed {
    logic le;
    logic lt;
    logic eq;
  } sti_flags_t;

endpackage

// ===== hw/rtl/sti_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted table cell
// Holds one table entry, compares it with the broadcast key and shifts.
// ----------------------------------------------------------------------------
module sti_cell #(
  parameter int DATA_WIDTH = sti_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  sti_pkg::sti_ctrl_t            ctrl,
  input  logic                          occupied,
  input  logic signed [DATA_WIDTH-1:0]  key,
  input  logic signed [DATA_WIDTH-1:0]  left_entry,
  input  logic signed [DATA_WIDTH-1:0]  right_entry,
  input  sti_pkg::sti_flags_t           left_flags,
  output sti_pkg::sti_flags_t           flags,
  output logic signed [DATA_WIDTH-1:0]  entry,
  output logic                          tgt
);

  logic signed [DATA_WIDTH-1:0] entry_r;
  sti_pkg::sti_flags_t          flags_r;
  sti_pkg::sti_flags_t          flags_nxt;

  // Unoccupied cells read as larger than any key.
  always_comb begin
    flags_nxt.le = occupied && (entry_r <= key);
    flags_nxt.lt = occupied && (entry_r < key);
    flags_nxt.eq = occupied && (entry_r == key);
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      flags_r <= flags_nxt;
    end
    if (ctrl.ins_en && !flags_r.le) begin
      entry_r <= left_flags.le ? key : left_entry;
    end else if (ctrl.del_en && !flags_r.lt) begin
      entry_r <= right_entry;
    end
  end

  // An insert lands at the first cell above the key; a delete hits the
  // lowest equal entry.
  assign tgt   = ctrl.op_del ? (flags_r.eq && left_flags.lt)
                             : (!flags_r.le && left_flags.le);
  assign flags = flags_r;
  assign entry = entry_r;

endmodule

// ===== hw/rtl/sti_enc.sv =====
// ----------------------------------------------------------------------------
// Sorted table position encoder
// Turns the one-hot target row of the cells into a position, in two steps.
// ----------------------------------------------------------------------------
module sti_enc #(
  parameter int CAPACITY = sti_pkg::CAPACITY_DEF,
  localparam int PW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                clk,
  input  logic                en,
  input  logic [CAPACITY-1:0] tgt_vec,
  output logic [PW-1:0]       pos,
  output logic                hit
);

  localparam int GS   = sti_pkg::GROUP_SIZE;
  localparam int NGRP = (CAPACITY + GS - 1) / GS;
  localparam int LW   = $clog2(GS);
  localparam int IW   = $clog2(NGRP * GS);

  logic [NGRP*GS-1:0] pad_vec;
  logic [NGRP-1:0]    grp_any_nxt;
  logic [LW-1:0]      grp_idx_nxt [NGRP];
  logic [NGRP-1:0]    grp_any_r;
  logic [LW-1:0]      grp_idx_r [NGRP];
  logic [IW-1:0]      pos_full;

  assign pad_vec = (NGRP*GS)'(tgt_vec);

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_nxt[g] = |pad_vec[g*GS +: GS];
      grp_idx_nxt[g] = '0;
      for (int b = 0; b < GS; b++) begin
        if (pad_vec[g*GS + b]) begin
          grp_idx_nxt[g] = grp_idx_nxt[g] | LW'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grp_any_r <= grp_any_nxt;
      for (int g = 0; g < NGRP; g++) begin
        grp_idx_r[g] <= grp_idx_nxt[g];
      end
    end
  end

  // At most one group is set, so the indexes can simply be ORed together.
  always_comb begin
    pos_full = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (grp_any_r[g]) begin
        pos_full = pos_full | IW'(g * GS) | IW'(grp_idx_r[g]);
      end
    end
  end

  assign pos = pos_full[PW-1:0];
  assign hit = |grp_any_r;

endmodule

// ===== hw/rtl/sorted_table_insert_delete_top.sv =====
// A request accepted in S_IDLE passes through S_CMP, S_ENC and S_UPD; in S_UPD
// it commits, and its result is registered, once out_ready or an empty output allows.
// A new request is taken only back in S_IDLE, after the compare, encode and
// shift steps that the cell row runs in turn for each request.
// Reset (rst_n low, synchronous) empties the table by clearing the count;
// entries are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// Sorted table with insert and delete
// Ascending table of signed values kept in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_table_insert_delete_top #(
  parameter int CAPACITY   = sti_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = sti_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [5:0]         out_position,
  output logic [6:0]         out_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_ENC  = 4'b0100,
    S_UPD  = 4'b1000
  } state_t;

  state_t                       state_r, state_nxt;
  logic                         op_r;
  logic signed [DATA_WIDTH-1:0] key_r;
  logic signed [63:0]           value_ext;
  logic [CW-1:0]                count_r, count_nxt;
  logic                         out_valid_r;
  sti_pkg::sti_status_t         status_r, status_nxt;
  logic [PW-1:0]                pos_r, pos_nxt;

  logic                         commit;
  logic                         full;
  logic                         empty;
  logic                         hit;
  logic [PW-1:0]                enc_pos;
  sti_pkg::sti_ctrl_t           ctrl;

  sti_pkg::sti_flags_t          flags   [CAPACITY];
  logic signed [DATA_WIDTH-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0]          tgt_vec;

  assign value_ext = 64'(in_value);
  assign in_ready  = (state_r == S_IDLE);
  assign commit    = (state_r == S_UPD) && (!out_valid_r || out_ready);
  assign full      = (count_r == CW'(CAPACITY));
  assign empty     = (count_r == '0);

  always_comb begin
    ctrl.op_del = op_r;
    ctrl.cmp_en = (state_r == S_CMP);
    ctrl.ins_en = commit && !op_r && !full;
    ctrl.del_en = commit && op_r && !empty && hit;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sti_pkg::sti_flags_t          left_flags;
    logic signed [DATA_WIDTH-1:0] left_entry;
    logic signed [DATA_WIDTH-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_flags = '{le: 1'b1, lt: 1'b1, eq: 1'b0};
      assign left_entry = key_r;
    end else begin : g_inner
      assign left_flags = flags[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_body
      assign right_entry = entries[i+1];
    end

    sti_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (count_r > CW'(i)),
      .key         (key_r),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .left_flags  (left_flags),
      .flags       (flags[i]),
      .entry       (entries[i]),
      .tgt         (tgt_vec[i])
    );
  end

  sti_enc #(
    .CAPACITY (CAPACITY)
  ) u_enc (
    .clk     (clk),
    .en      (state_r == S_ENC),
    .tgt_vec (tgt_vec),
    .pos     (enc_pos),
    .hit     (hit)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP:   state_nxt = S_ENC;
      S_ENC:   state_nxt = S_UPD;
      S_UPD: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = sti_pkg::ST_OK;
    pos_nxt    = '0;
    if (!op_r) begin
      if (full) begin
        status_nxt = sti_pkg::ST_FULL;
      end else begin
        pos_nxt   = enc_pos;
        count_nxt = count_r + CW'(1);
      end
    end else if (empty) begin
      status_nxt = sti_pkg::ST_EMPTY;
    end else if (!hit) begin
      status_nxt = sti_pkg::ST_MISSING;
    end else begin
      pos_nxt   = enc_pos;
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= in_op;
      key_r <= value_ext[DATA_WIDTH-1:0];
    end
    if (commit) begin
      status_r <= status_nxt;
      pos_r    <= pos_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_position = 6'(pos_r);
  assign out_count    = 7'(count_r);

  `STI_ASSERT(a_count_bound, count_r <= CW'(CAPACITY), "count exceeds capacity")
  `STI_ASSERT(a_tgt_onehot, (state_r != S_ENC) || $onehot0(tgt_vec),
    "more than one cell claims the target position")
  `STI_ASSERT_NEXT(a_ins_count, commit && !op_r && !full,
    count_r == $past(count_r) + CW'(1), "insert did not grow the count")
  `STI_ASSERT_NEXT(a_miss_count, commit && op_r && !hit,
    $stable(count_r), "failed delete changed the count")

endmodule
